/* hdl/ptw_pkg.sv */
// Types and constants shared by the page table walker and its checker.
package ptw_pkg;

  localparam int unsigned VaW     = 48;
  localparam int unsigned EntryW  = 64;
  localparam int unsigned PaW     = 52;
  localparam int unsigned StatusW = 2;
  localparam int unsigned InDataW = 112;
  localparam int unsigned OutDataW = 56;

  typedef enum logic [2:0] {
    LVL_IDLE = 3'd0,
    LVL_PML4 = 3'd1,
    LVL_PDPT = 3'd2,
    LVL_PD   = 3'd3,
    LVL_PT   = 3'd4
  } level_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_PRES  = 2'd1,
    ST_IDLE_ENTRY = 2'd2
  } status_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_ENTRY = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_FETCH = 1'b0,
    KIND_FINAL = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e          kind;
    logic [PaW-1:0] addr;
    status_e        status;
  } result_t;

  localparam int unsigned PresentBit = 0;
  localparam int unsigned LargeBit   = 7;

endpackage

/* hdl/four_level_page_table_walker.sv */
// Four-level page table walker: one request or returned entry in, one result out.
// An accepted transfer's result is registered (in the skid if the output waits) before
// the master side sees it. Throughput: one transfer per cycle while the skid is empty;
// the two-entry output register (result, skid) keeps the slave side open while one waits.
// Reset (rst_ni low, asynchronous): walker idle, held address and table base zero,
// no result pending.
module four_level_page_table_walker
  import ptw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [PaW-1:0]      cfg_data_i,     // table_base
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [47:0] virtual_address, [111:48] entry_data
  input  logic                s_axis_tuser,   // [0] cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [51:0] phys_addr, [53:52] status
  output logic                m_axis_tuser    // [0] kind
);

  logic [PaW-1:0]    table_base_q;
  level_e            level_q, level_d;
  logic [VaW-1:0]    vaddr_q, vaddr_d;
  result_t           out_q, skid_q, res;
  logic              out_vld_q, skid_vld_q;

  logic [VaW-1:0]    in_va;
  logic [EntryW-1:0] e;
  logic              s_fire, m_fire;
  logic [23:0]       frame;

  assign in_va  = s_axis_tdata[VaW-1:0];
  assign e      = s_axis_tdata[InDataW-1:VaW];
  assign frame  = e[35:12];
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = out_vld_q && m_axis_tready;

  always_comb begin
    level_d = level_q;
    vaddr_d = vaddr_q;
    res     = '{kind: KIND_FINAL, addr: '0, status: ST_IDLE_ENTRY};
    if (cmd_e'(s_axis_tuser) == CMD_START) begin
      vaddr_d = in_va;
      level_d = LVL_PML4;
      res = '{kind: KIND_FETCH, status: ST_OK,
              addr: {table_base_q[PaW-1:4], 4'b0} + {40'b0, in_va[47:39], 3'b0}};
    end else begin
      case (level_q)
        LVL_PML4: begin
          if (!e[PresentBit]) begin
            level_d = LVL_IDLE;
            res = '{kind: KIND_FINAL, addr: '0, status: ST_NOT_PRES};
          end else begin
            level_d = LVL_PDPT;
            res = '{kind: KIND_FETCH, status: ST_OK,
                    addr: {16'b0, frame, vaddr_q[38:30], 3'b0}};
          end
        end
        LVL_PDPT: begin
          if (!e[PresentBit]) begin
            level_d = LVL_IDLE;
            res = '{kind: KIND_FINAL, addr: '0, status: ST_NOT_PRES};
          end else if (e[LargeBit]) begin
            level_d = LVL_IDLE;
            res = '{kind: KIND_FINAL, status: ST_OK,
                    addr: {e[51:30], vaddr_q[29:0]}};
          end else begin
            level_d = LVL_PD;
            res = '{kind: KIND_FETCH, status: ST_OK,
                    addr: {16'b0, frame, vaddr_q[29:21], 3'b0}};
          end
        end
        LVL_PD: begin
          if (!e[PresentBit]) begin
            level_d = LVL_IDLE;
            res = '{kind: KIND_FINAL, addr: '0, status: ST_NOT_PRES};
          end else if (e[LargeBit]) begin
            level_d = LVL_IDLE;
            res = '{kind: KIND_FINAL, status: ST_OK,
                    addr: {16'b0, frame, 12'b0} + {31'b0, vaddr_q[20:0]}};
          end else begin
            level_d = LVL_PT;
            res = '{kind: KIND_FETCH, status: ST_OK,
                    addr: {16'b0, frame, vaddr_q[20:12], 3'b0}};
          end
        end
        LVL_PT: begin
          level_d = LVL_IDLE;
          if (!e[PresentBit] || frame == '0) begin
            res = '{kind: KIND_FINAL, addr: '0, status: ST_NOT_PRES};
          end else begin
            res = '{kind: KIND_FINAL, status: ST_OK,
                    addr: {16'b0, frame, vaddr_q[11:0]}};
          end
        end
        default: begin
          level_d = LVL_IDLE;
          res = '{kind: KIND_FINAL, addr: '0, status: ST_IDLE_ENTRY};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_base_q <= '0;
      level_q      <= LVL_IDLE;
      vaddr_q      <= '0;
      out_vld_q    <= 1'b0;
      skid_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        table_base_q <= cfg_data_i;
      end
      if (s_fire) begin
        level_q <= level_d;
        vaddr_q <= vaddr_d;
      end
      if (skid_vld_q) begin
        if (m_fire) begin
          skid_vld_q <= 1'b0;
        end
      end else if (s_fire) begin
        if (!out_vld_q || m_fire) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (m_fire) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (m_fire) begin
        out_q <= skid_q;
      end
    end else if (s_fire) begin
      if (!out_vld_q || m_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign s_axis_tready = !skid_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - PaW - StatusW){1'b0}}, out_q.status, out_q.addr};
  assign m_axis_tuser  = out_q.kind;

endmodule

/* hdl/ptw_checker.sv */
// Port-level assertions for the page table walker, bound to the top level.
module ptw_checker
  import ptw_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  // fetch requests always carry ok status
  a_fetch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_FETCH) |-> m_axis_tdata[53:52] == ST_OK)
    else $error("fetch request with non-ok status");

  // faults report a final result at address zero
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[53:52] != ST_OK) |->
      (m_axis_tuser == KIND_FINAL && m_axis_tdata[51:0] == '0))
    else $error("fault result with nonzero address or fetch kind");

  // a transfer accepted into an empty output shows up next cycle
  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("accepted transfer produced no result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (.*);
